/* rtl/ssucc_pkg.sv */
// Shared types and constants for the single successor table.
// Item and result structs, opcode and status codes, register map, store port structs.
// No dependencies.
package ssucc_pkg;

    localparam int NODE_W  = 10;
    localparam int LIMIT_W = 11;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [LIMIT_W-1:0] limit_t;

    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FAILED  = 2'd2;

    // Word index of the node limit register (byte address 4*index)
    localparam logic [ADDR_W-3:0] REG_NODE_LIMIT = '0;
    localparam limit_t            LIMIT_RESET    = 11'd1024;

    typedef struct packed {
        logic [1:0] opcode;
        node_t      source_node;
        node_t      target_node;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        node_t      successor_node;
        logic       fanout_seen;
        node_t      first_fanout_node;
    } result_t;

    typedef struct packed {
        logic  en;
        node_t succ;
    } store_wr_t;

    typedef struct packed {
        logic  hit;
        node_t succ;
    } store_rd_t;

endpackage

/* rtl/ssucc_cfg.sv */
// APB register block holding the node limit.
// Depends on ssucc_pkg.
module ssucc_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssucc_pkg::ADDR_W-1:0] paddr,
    input  logic [ssucc_pkg::DATA_W-1:0] pwdata,
    output logic [ssucc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output ssucc_pkg::limit_t          node_limit
);
    import ssucc_pkg::*;

    limit_t node_limit_reg;
    logic   sel_limit;

    assign sel_limit  = (paddr[ADDR_W-1:2] == REG_NODE_LIMIT);
    assign pready     = 1'b1;
    assign node_limit = node_limit_reg;
    assign prdata     = sel_limit ? DATA_W'(node_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_limit)
        begin
            node_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

endmodule

/* rtl/ssucc_store.sv */
// Successor memory organized in rows, with per-row live marks and write forwarding.
// Depends on ssucc_pkg.
module ssucc_store #(
    parameter int MAX_NODES = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  ssucc_pkg::node_t      rd_node,
    input  ssucc_pkg::node_t      cur_node,
    input  logic                  clear,
    input  ssucc_pkg::store_wr_t  wr,
    output ssucc_pkg::store_rd_t  look
);
    import ssucc_pkg::*;

    localparam int NODE_BITS = $clog2(MAX_NODES);
    localparam int IDX_W     = (NODE_BITS < 2) ? 2 : NODE_BITS;
    localparam int LANE_W    = (IDX_W > 9) ? IDX_W - 8 : 1;
    localparam int ROW_W     = IDX_W - LANE_W;
    localparam int ROWS      = 2 ** ROW_W;
    localparam int LANES     = 2 ** LANE_W;

    typedef struct packed {
        logic  v;
        node_t s;
    } slot_t;

    typedef slot_t [LANES-1:0] row_t;

    row_t               mem [ROWS];
    row_t               rd_data_reg;
    row_t               fwd_data_reg;
    logic [ROW_W-1:0]   fwd_row_reg;
    logic               fwd_valid_reg;
    logic [ROWS-1:0]    row_live_reg;

    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   cur_idx;
    logic [ROW_W-1:0]   rd_row;
    logic [ROW_W-1:0]   cur_row;
    logic [LANE_W-1:0]  cur_lane;
    row_t               cur_data;
    row_t               live;
    row_t               wr_data;

    assign rd_idx   = IDX_W'(rd_node);
    assign cur_idx  = IDX_W'(cur_node);
    assign rd_row   = rd_idx[IDX_W-1:LANE_W];
    assign cur_row  = cur_idx[IDX_W-1:LANE_W];
    assign cur_lane = cur_idx[LANE_W-1:0];

    // The read was issued at accept; take the last write if it hit the same row
    assign cur_data = (fwd_valid_reg && (fwd_row_reg == cur_row)) ? fwd_data_reg : rd_data_reg;
    // A row not written since the last begin reads as empty
    assign live     = row_live_reg[cur_row] ? cur_data : '0;

    assign look.hit  = live[cur_lane].v;
    assign look.succ = live[cur_lane].s;

    always_comb
    begin
        wr_data             = live;
        wr_data[cur_lane].v = 1'b1;
        wr_data[cur_lane].s = wr.succ;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_row];
        end
        if (wr.en)
        begin
            mem[cur_row] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            fwd_row_reg  <= cur_row;
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            row_live_reg  <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                fwd_valid_reg         <= 1'b1;
                row_live_reg[cur_row] <= 1'b1;
            end
            else if (clear)
            begin
                row_live_reg <= '0;
            end
        end
    end

endmodule

/* rtl/single_successor_table.sv */
// Single successor table: one result per item, via an input register and a result register.
// Throughput is one item per cycle unless result_stall holds the output, set by the row
// read-modify-write of the successor memory, last written row forwarded to the next item.
// Reset clears the row live marks, fanout record and failure flag at once and sets the
// node limit to 1024; no clearing pass, items are taken in the first cycle after reset.
module single_successor_table #(
    parameter int MAX_NODES = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssucc_pkg::ADDR_W-1:0] paddr,
    input  logic [ssucc_pkg::DATA_W-1:0] pwdata,
    output logic [ssucc_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  ssucc_pkg::item_t             item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output ssucc_pkg::result_t           result
);
    import ssucc_pkg::*;

    limit_t    node_limit;
    item_t     in_reg;
    logic      in_valid_reg;
    result_t   out_reg;
    logic      out_valid_reg;
    logic      failed_reg;
    logic      fan_reg;
    node_t     low_reg;

    logic      failed_next;
    logic      fan_next;
    node_t     low_next;
    logic      accept;
    logic      advance;
    logic      src_ok;
    logic      dst_ok;
    logic      clear;
    result_t   res;
    store_wr_t st_wr;
    store_rd_t st_rd;

    ssucc_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .node_limit (node_limit)
    );

    ssucc_store #(
        .MAX_NODES (MAX_NODES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_node  (item.source_node),
        .cur_node (in_reg.source_node),
        .clear    (clear),
        .wr       (st_wr),
        .look     (st_rd)
    );

    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;
    assign clear      = advance && (in_reg.opcode == OP_BEGIN);

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Effective limit is node_limit saturated to the table size
    assign src_ok = ({1'b0, in_reg.source_node} < node_limit)
                    && (32'(in_reg.source_node) < MAX_NODES);
    assign dst_ok = ({1'b0, in_reg.target_node} < node_limit)
                    && (32'(in_reg.target_node) < MAX_NODES);

    always_comb
    begin
        failed_next        = failed_reg;
        fan_next           = fan_reg;
        low_next           = low_reg;
        st_wr              = '0;
        res                = '0;
        res.status         = ST_OK;
        case (in_reg.opcode)
            OP_BEGIN:
            begin
                failed_next = 1'b0;
                fan_next    = 1'b0;
                low_next    = '0;
            end
            OP_INSERT:
            begin
                if (failed_reg)
                begin
                    res.status = ST_FAILED;
                end
                else if (!(src_ok && dst_ok))
                begin
                    res.status  = ST_INVALID;
                    failed_next = 1'b1;
                end
                else if (!st_rd.hit)
                begin
                    st_wr.en   = advance;
                    st_wr.succ = in_reg.target_node;
                end
                else if (!fan_reg || (in_reg.source_node < low_reg))
                begin
                    fan_next = 1'b1;
                    low_next = in_reg.source_node;
                end
            end
            OP_QUERY:
            begin
                if (!failed_reg && src_ok && st_rd.hit)
                begin
                    res.found          = 1'b1;
                    res.successor_node = st_rd.succ;
                end
            end
            default:
            begin
            end
        endcase
        res.fanout_seen       = !failed_next && fan_next;
        res.first_fanout_node = res.fanout_seen ? low_next : '0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            failed_reg    <= 1'b0;
            fan_reg       <= 1'b0;
            low_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                failed_reg    <= failed_next;
                fan_reg       <= fan_next;
                low_reg       <= low_next;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Store only the first edge out of a node, and never in a failed build
    assert property (@(posedge clk) disable iff (!rst_n)
        st_wr.en |-> (!st_rd.hit && !failed_reg && advance))
        else $error("successor written over a recorded entry or in a failed build");

    // Never overwrite an item that has not moved on
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !advance) |-> !in_valid_reg)
        else $error("input register overwritten while held");

    // A failed build answers every query with not found
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && failed_reg && (in_reg.opcode == OP_QUERY)) |=> !out_reg.found)
        else $error("query found a successor in a failed build");

    // A failed build never reports fanout
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && failed_next) |=> !out_reg.fanout_seen)
        else $error("fanout reported in a failed build");
`endif

endmodule
